// ===== hw/rtl/tss_pkg.sv =====
// ---------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the timed swing sequencer.
// ---------------------------------------------------------------------------
package tss_pkg;

  // Field widths
  localparam int NOW_W   = 32;
  localparam int INT_W   = 8;
  localparam int PHASE_W = 2;
  localparam int POS_W   = 13;
  localparam int VEL_W   = 13;
  localparam int SERVO_W = 11;
  localparam int MDUR_W  = 15;
  localparam int DWELL_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 40;   // 32 + 8
  localparam int OUT_DATA_W = 56;   // 2 + 13 + 13 + 13 + 11 = 52, padded

  // Parameter defaults
  localparam int DWELL_MS_DEF         = 500;
  localparam int AMPLITUDE_TENTHS_DEF = 450;
  localparam int MARGIN_MS_DEF        = 300;

  // Fixed constants
  localparam int VEL_FLOOR     = 50;
  localparam int MS_PER_TRAVEL = 1500;   // 2*amp*1500 / vel gives ms
  localparam int MOVE_DUR_MAX  = 32767;
  localparam int MOVE_DUR_RST  = 1500;
  localparam int SERVO_CENTER  = 900;
  localparam int SERVO_MAX     = 1800;
  localparam int LIMIT_RST     = 3600;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMS_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMS_MAX = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp: below lo gives lo, else above hi gives hi
  function automatic logic signed [POS_W-1:0] clamp_pos(
    input logic signed [POS_W-1:0] x,
    input logic signed [POS_W-1:0] lo,
    input logic signed [POS_W-1:0] hi
  );
    logic signed [POS_W-1:0] r;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    else r = x;
    return r;
  endfunction

endpackage

// ===== hw/rtl/tss_div.sv =====
// ---------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tss_div #(
  parameter int DVD_W = 22,
  parameter int DSR_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tss_pkg::div_ctl_t   ctl,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DSR_W-1:0]    divisor,
  output tss_pkg::div_stat_t  stat,
  output logic [DVD_W-1:0]    quotient
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_dif;
  logic             fits;
  logic [DSR_W-1:0] rem_nxt;

  // remainder stays below the divisor, so DSR_W bits hold it
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, dsr_r};
  assign fits    = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt = fits ? rem_dif[DSR_W-1:0] : rem_sh[DSR_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== hw/rtl/timed_swing_sequencer.sv =====
// ---------------------------------------------------------------------------
// timed_swing_sequencer
// Four-phase swing sequencer: move up, dwell, move down, dwell, timed by
// the millisecond stamp of each request.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | Handshake              | Payload
//  --------+-----+------------------------+----------------------------------
//  in_     | in  | in_tvalid / in_tready  | now_ms, intensity
//  out_    | out | out_tvalid / out_tready| phase, targets, velocity, servo
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (limits)
//
// Sequence: a request is accepted in idle, decided in the calc state, and
// its result is registered in the done state. When the phase steps into a
// move, the move time is recomputed by the serial divider, one quotient bit
// per cycle, in the div state between calc and done; its width DVD_W is the
// bit width of 3000 * AMPLITUDE_TENTHS.
// Reset: synchronous, active low; phase 0, phase start 0, move time 1500 ms,
// limits at +-3600. No clearing pass.
// Stalls: in_tready is high only in idle. The result register frees the
// sequencer, so a new request is taken while a result waits on out_tready;
// a finished request waits in its last state while the register is full.
// cfg_ready is always high; writes are expected only while idle.
// ---------------------------------------------------------------------------
module timed_swing_sequencer #(
  parameter int DWELL_MS         = tss_pkg::DWELL_MS_DEF,
  parameter int AMPLITUDE_TENTHS = tss_pkg::AMPLITUDE_TENTHS_DEF,
  parameter int MARGIN_MS        = tss_pkg::MARGIN_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tss_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] now_ms, [39:32] intensity
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tss_pkg::OUT_DATA_W-1:0]    out_tdata,  // [1:0] phase_now,
                                                        // [14:2] head_target,
                                                        // [27:15] arms_target,
                                                        // [40:28] traverse_velocity,
                                                        // [51:41] servo_angle, [55:52] 0
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tss_pkg::POS_W-1:0]         cfg_data
);
  import tss_pkg::*;

  // travel numerator: 2 * amplitude * 1500
  localparam int DIVIDEND = 2 * AMPLITUDE_TENTHS * MS_PER_TRAVEL;
  localparam int DVD_W    = $clog2(DIVIDEND + 1);
  localparam int SUM_W    = (DVD_W + 1 > 16) ? DVD_W + 1 : 16;

  localparam logic [DVD_W-1:0]   DIVIDEND_V = DVD_W'(DIVIDEND);
  localparam logic [SUM_W-1:0]   MARGIN_V   = SUM_W'(MARGIN_MS);
  localparam logic [SUM_W-1:0]   MDUR_MAX_V = SUM_W'(MOVE_DUR_MAX);
  localparam logic [DWELL_W-1:0] DWELL_V    = DWELL_W'(DWELL_MS);
  localparam logic signed [POS_W-1:0] AMP_V = POS_W'(AMPLITUDE_TENTHS);
  localparam logic [VEL_W-1:0]   VEL_FLOOR_V = VEL_W'(VEL_FLOOR);

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [PHASE_W-1:0] phase_r;
  logic [NOW_W-1:0]   phase_start_r;
  logic [MDUR_W-1:0]  move_dur_r;

  logic signed [POS_W-1:0] head_min_r, head_max_r, arms_min_r, arms_max_r;

  // captured request
  logic [NOW_W-1:0]   now_r;
  logic [VEL_W-1:0]   vel_r;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // -------------------------------------------------------------------------
  // Divider
  // -------------------------------------------------------------------------
  div_ctl_t          dctl;
  div_stat_t         dstat;
  logic [DVD_W-1:0]  quotient;

  tss_div #(
    .DVD_W (DVD_W),
    .DSR_W (VEL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (DIVIDEND_V),
    .divisor  (vel_r),
    .stat     (dstat),
    .quotient (quotient)
  );

  // -------------------------------------------------------------------------
  // Datapath terms
  // -------------------------------------------------------------------------
  logic [INT_W-1:0]  in_intensity;
  logic [VEL_W-1:0]  vel_raw;
  logic [VEL_W-1:0]  vel_in;
  logic [NOW_W-1:0]  elapsed;
  logic [NOW_W-1:0]  dur;
  logic              advance;
  logic              enter_move;   // current phase is a dwell
  logic [SUM_W-1:0]  md_sum;
  logic [MDUR_W-1:0] md_clamped;

  // intensity * 18 as two shifts
  assign in_intensity = in_tdata[NOW_W +: INT_W];
  assign vel_raw = (VEL_W'(in_intensity) << 4) + (VEL_W'(in_intensity) << 1);
  assign vel_in  = (vel_raw < VEL_FLOOR_V) ? VEL_FLOOR_V : vel_raw;

  // elapsed wraps modulo 2^32
  assign elapsed    = now_r - phase_start_r;
  assign dur        = phase_r[0] ? NOW_W'(DWELL_V) : NOW_W'(move_dur_r);
  assign advance    = (elapsed >= dur);
  assign enter_move = phase_r[0];

  assign md_sum     = SUM_W'(quotient) + MARGIN_V;
  assign md_clamped = (md_sum > MDUR_MAX_V) ? MDUR_W'(MOVE_DUR_MAX) : md_sum[MDUR_W-1:0];

  // result fields from the updated phase
  logic signed [POS_W-1:0]   target;
  logic signed [POS_W-1:0]   head_t, arms_t;
  logic signed [POS_W-1:0]   servo_raw;
  logic [SERVO_W-1:0]        servo;

  assign target    = (phase_r < 2'd2) ? AMP_V : -AMP_V;
  assign head_t    = clamp_pos(target, head_min_r, head_max_r);
  assign arms_t    = clamp_pos(target, arms_min_r, arms_max_r);
  assign servo_raw = target + POS_W'(SERVO_CENTER);
  always_comb begin
    if (servo_raw < 0) servo = '0;
    else if (servo_raw > POS_W'(SERVO_MAX)) servo = SERVO_W'(SERVO_MAX);
    else servo = servo_raw[SERVO_W-1:0];
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CALC;
      ST_CALC: state_nxt = (advance && enter_move) ? ST_DIV : ST_DONE;
      ST_DIV:  if (dstat.done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    dctl.start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_CALC: dctl.start = advance && enter_move;
      ST_DIV:  ;
      ST_DONE: out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r <= in_tdata[NOW_W-1:0];
      vel_r <= vel_in;
    end
  end

  // phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      phase_start_r <= '0;
      move_dur_r    <= MDUR_W'(MOVE_DUR_RST);
    end else begin
      if (state_r == ST_CALC && advance) begin
        phase_r       <= phase_r + 1'b1;
        phase_start_r <= now_r;
      end
      if (state_r == ST_DIV && dstat.done) begin
        move_dur_r <= md_clamped;
      end
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_min_r <= -POS_W'(LIMIT_RST);
      head_max_r <=  POS_W'(LIMIT_RST);
      arms_min_r <= -POS_W'(LIMIT_RST);
      arms_max_r <=  POS_W'(LIMIT_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAD_MIN: head_min_r <= cfg_data;
        CFG_HEAD_MAX: head_max_r <= cfg_data;
        CFG_ARMS_MIN: arms_min_r <= cfg_data;
        CFG_ARMS_MAX: arms_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {4'b0, servo, vel_r, arms_t, head_t, phase_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != $past(phase_r)) |->
      (phase_r == PHASE_W'($past(phase_r) + 1'b1)) && ($past(state_r) == ST_CALC))
    else $error("phase moved other than one step from the decision state");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (dstat.busy || dstat.done) |-> (state_r == ST_DIV))
    else $error("divider active outside the divide state");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> advance && phase_r[0])
    else $error("divider started without a move phase being entered");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result presented without a finished request");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed swing sequencer. A clocked driver feeds
// time-stamped requests from a queue, a clocked monitor predicts each result
// at accept time and checks every output field against the oldest
// prediction. Limits are reprogrammed between drained phases.
// ---------------------------------------------------------------------------
module tb_top;
  import tss_pkg::*;

  localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run
  localparam int SETTLE      = 64;      // covers accept-to-result incl. divider
  localparam int RUN_LEN     = 150;
  localparam int MAX_PRINTS  = 30;

  typedef enum logic [PHASE_W-1:0] {
    PH_MOVE_UP,
    PH_DWELL_UP,
    PH_MOVE_DOWN,
    PH_DWELL_DOWN
  } swing_phase_t;

  typedef struct packed {
    logic [INT_W-1:0] inten;
    logic [NOW_W-1:0] now;
  } swing_req_t;

  // matches out_tdata, lowest field last
  typedef struct packed {
    logic [OUT_DATA_W-PHASE_W-2*POS_W-VEL_W-SERVO_W-1:0] pad;
    logic [SERVO_W-1:0]        servo;
    logic [VEL_W-1:0]          vel;
    logic signed [POS_W-1:0]   arms;
    logic signed [POS_W-1:0]   head;
    logic [PHASE_W-1:0]        phase;
  } swing_res_t;

  // ---------------------------------------------------------------- signals
  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_W-1:0]     in_tdata   = '0;   // [31:0] now_ms, [39:32] intensity
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    out_tdata;         // phase, head, arms, velocity, servo, pad
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = CFG_HEAD_MIN;
  logic [POS_W-1:0]         cfg_data   = '0;

  timed_swing_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------- bench state
  swing_req_t   req_q[$];        // requests waiting for the driver
  swing_res_t   swing_exp_q[$];  // predicted results, oldest first
  logic         gaps_on = 1'b1;  // random idling on both sides
  logic [NOW_W-1:0] stamp = '0;  // running time base for generated requests

  int unsigned  cycle_cnt = 0;
  int unsigned  req_taken = 0;   // requests accepted by the block
  int unsigned  res_taken = 0;   // results accepted from the block
  int unsigned  err_cnt = 0;
  int unsigned  phase_steps = 0;
  int unsigned  time_jumps = 0;
  int unsigned  limit_sets = 0;

  // predictor copy of the sequencer state and limit registers
  swing_phase_t            seq_phase;
  logic [NOW_W-1:0]        seq_start;
  logic [31:0]             seq_move_ms;
  logic signed [POS_W-1:0] lim [4];

  // ---------------------------------------------------------- predictor
  function automatic logic signed [POS_W-1:0] limit_pos(
    input logic signed [POS_W-1:0] x,
    input logic signed [POS_W-1:0] lo,
    input logic signed [POS_W-1:0] hi
  );
    // with inverted limits, a value below lo gives lo, any other value gives hi
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic swing_res_t step_swing(input swing_req_t rq);
    swing_res_t              r;
    logic [VEL_W-1:0]        vel;
    logic [31:0]             span;
    logic [31:0]             mv;
    logic signed [POS_W-1:0] tgt;
    int                      srv;
    vel = VEL_W'(rq.inten * 18);
    if (vel < VEL_FLOOR) vel = VEL_W'(VEL_FLOOR);
    if (seq_phase == PH_DWELL_UP || seq_phase == PH_DWELL_DOWN) span = DWELL_MS_DEF;
    else span = seq_move_ms;
    // elapsed time is modulo 2^32, so a backwards step looks like a long wait
    if (32'(rq.now - seq_start) >= span) begin
      seq_phase = swing_phase_t'(PHASE_W'(seq_phase + 1));
      seq_start = rq.now;
      phase_steps++;
      if (seq_phase == PH_MOVE_UP || seq_phase == PH_MOVE_DOWN) begin
        mv = (2 * AMPLITUDE_TENTHS_DEF * MS_PER_TRAVEL) / vel + MARGIN_MS_DEF;
        seq_move_ms = (mv > MOVE_DUR_MAX) ? MOVE_DUR_MAX : mv;
      end
    end
    if (seq_phase == PH_MOVE_UP || seq_phase == PH_DWELL_UP) begin
      tgt = POS_W'(AMPLITUDE_TENTHS_DEF);
    end else begin
      tgt = POS_W'(-AMPLITUDE_TENTHS_DEF);
    end
    srv = SERVO_CENTER + tgt;
    if (srv < 0) srv = 0;
    if (srv > SERVO_MAX) srv = SERVO_MAX;
    r.pad   = '0;
    r.phase = seq_phase;
    r.head  = limit_pos(tgt, lim[CFG_HEAD_MIN], lim[CFG_HEAD_MAX]);
    r.arms  = limit_pos(tgt, lim[CFG_ARMS_MIN], lim[CFG_ARMS_MAX]);
    r.vel   = vel;
    r.servo = SERVO_W'(srv);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0d, expected %0d", $time, res_taken, field,
               got, want);
  endtask

  // ------------------------------------------------------------ monitor
  // Samples at the rising edge: checks results first so a result can never
  // be matched against the request accepted on the same edge.
  always @(posedge clk) begin
    swing_res_t got;
    swing_res_t want;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               swing_exp_q.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = swing_res_t'(out_tdata);
        if (swing_exp_q.size() == 0) begin
          report_mismatch("unexpected result, phase", got.phase, -1);
        end else begin
          want = swing_exp_q.pop_front();
          if (got.phase !== want.phase) report_mismatch("phase_now", got.phase, want.phase);
          if (got.head !== want.head) report_mismatch("head_target", got.head, want.head);
          if (got.arms !== want.arms) report_mismatch("arms_target", got.arms, want.arms);
          if (got.vel !== want.vel)
            report_mismatch("traverse_velocity", got.vel, want.vel);
          if (got.servo !== want.servo) report_mismatch("servo_angle", got.servo, want.servo);
          if (got.pad !== want.pad) report_mismatch("padding", got.pad, want.pad);
        end
        res_taken++;
      end
      if (in_tvalid && in_tready) begin
        swing_exp_q.push_back(step_swing(swing_req_t'(in_tdata)));
        req_taken++;
      end
      if (cfg_valid && cfg_ready) lim[cfg_index] = cfg_data;
    end
  end

  // ------------------------------------------------------------- driver
  // Falling-edge request driver with a random gap drawn per request while gaps_on is set.
  int unsigned drv_seen = 0;
  int unsigned send_wait = 0;

  always @(negedge clk) begin
    logic       nxt_valid;
    swing_req_t rq;
    if (rst_n) begin
      nxt_valid = in_tvalid;
      if (in_tvalid && drv_seen != req_taken) begin
        drv_seen  = req_taken;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (req_q.size() != 0) begin
          rq        = req_q.pop_front();
          in_tdata <= rq;
          nxt_valid = 1'b1;
          send_wait = gaps_on ? $urandom_range(0, 11) : 0;
        end
      end
      in_tvalid <= nxt_valid;   // single update per step keeps valid steady
    end
  end

  // ----------------------------------------------------------- receiver
  // Back-pressure: after each taken result, hold ready low for a random stall while gaps_on is set.
  int unsigned rcv_seen = 0;
  int unsigned rcv_wait = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (rcv_seen != res_taken) begin
        rcv_seen = res_taken;
        rcv_wait = gaps_on ? $urandom_range(0, 11) : 0;
      end
      if (rcv_wait != 0) begin
        rcv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------- stimulus
  task automatic queue_req(input logic [NOW_W-1:0] now, input int inten);
    swing_req_t rq;
    rq.now   = now;
    rq.inten = inten[INT_W-1:0];
    req_q.push_back(rq);
    stamp = now;
  endtask

  // Mostly forward-moving time with random speed; small creeps land on exact
  // phase boundaries, a few wild jumps and backward steps act as noise.
  task automatic queue_swing_run(input int n);
    int sel;
    int inten;
    logic [NOW_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      t   = stamp;
      if (sel < 4) begin
        t = $urandom();
        time_jumps++;
      end else if (sel < 7) begin
        t = t - $urandom_range(1, 2000);
        time_jumps++;
      end else if (sel < 25) t = t + $urandom_range(1, 4);
      else if (sel < 75) t = t + $urandom_range(5, 400);
      else if (sel < 95) t = t + $urandom_range(400, 1500);
      else t = t + $urandom_range(1500, 30000);
      // slow intensities give the long moves near the velocity floor
      inten = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      queue_req(t, inten);
    end
  endtask

  // Sender holds off until every predicted result has been taken, then the
  // block is given time to return to idle.
  task automatic drain();
    while (req_q.size() != 0 || in_tvalid || swing_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[POS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input int hmin, input int hmax, input int amin, input int amax);
    write_limit(CFG_HEAD_MIN, hmin);
    write_limit(CFG_HEAD_MAX, hmax);
    write_limit(CFG_ARMS_MIN, amin);
    write_limit(CFG_ARMS_MAX, amax);
    limit_sets++;
  endtask

  initial begin
    // predictor reset state
    seq_phase         = PH_MOVE_UP;
    seq_start         = '0;
    seq_move_ms       = MOVE_DUR_RST;
    lim[CFG_HEAD_MIN] = POS_W'(-LIMIT_RST);
    lim[CFG_HEAD_MAX] = POS_W'(LIMIT_RST);
    lim[CFG_ARMS_MIN] = POS_W'(-LIMIT_RST);
    lim[CFG_ARMS_MAX] = POS_W'(LIMIT_RST);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset-time move, exact boundaries, velocity floor and top,
    // longest move, time wrap and time going backwards, default limits.
    queue_req(32'd0, 0);
    queue_req(32'd1499, 255);
    queue_req(32'd1500, 100);          // exactly at the first move end
    queue_req(32'd1999, 1);
    queue_req(32'd2000, 2);            // floor velocity: longest move
    queue_req(32'd29299, 3);
    queue_req(32'd29300, 255);
    queue_req(32'd29799, 128);
    queue_req(32'd29800, 127);         // velocity 2286 sets the move time
    queue_req(32'd30393, 200);
    queue_req(32'd30394, 55);
    queue_req(32'd30894, 0);
    queue_req(32'hFFFF_FF00, 255);
    queue_req(32'hFFFF_FFFF, 170);
    queue_req(32'h0000_00F3, 85);
    queue_req(32'h0000_00F4, 99);      // elapsed 500 across the wrap, move still running
    queue_req(32'h0000_0010, 77);      // backwards in time
    queue_req(32'h8000_0000, 64);
    queue_req(32'h5555_5555, 101);
    queue_req(32'hAAAA_AAAA, 254);
    queue_swing_run(RUN_LEN);
    drain();

    // widest 13-bit limits, no idling
    set_limits(-4096, 4095, -4096, 4095);
    gaps_on = 1'b0;
    queue_swing_run(RUN_LEN);
    drain();

    // limits that clip both targets
    set_limits(-100, 200, 0, 0);
    gaps_on = 1'b1;
    queue_swing_run(RUN_LEN);
    drain();

    // inverted limits on both motors
    set_limits(500, -500, 100, -100);
    queue_swing_run(RUN_LEN);
    drain();

    // arbitrary register contents
    set_limits($urandom_range(0, 8191), $urandom_range(0, 8191),
               $urandom_range(0, 8191), $urandom_range(0, 8191));
    gaps_on = 1'b0;
    queue_swing_run(100);
    drain();
    set_limits($urandom_range(0, 8191), $urandom_range(0, 8191),
               $urandom_range(0, 8191), $urandom_range(0, 8191));
    gaps_on = 1'b1;
    queue_swing_run(100);
    drain();

    // back to the documented travel range
    set_limits(-3600, 3600, -3600, 3600);
    queue_swing_run(RUN_LEN);
    drain();

    $display("checked %0d results from %0d requests: %0d phase steps, %0d time jumps",
             res_taken, req_taken, phase_steps, time_jumps);
    $display("limit settings exercised: %0d plus reset defaults, mismatches: %0d",
             limit_sets, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== timed_swing_sequencer.f =====
hw/rtl/tss_pkg.sv
hw/rtl/tss_div.sv
hw/rtl/timed_swing_sequencer.sv
tb/tb_top.sv
